// File: sv/dus_pkg.sv
// Package: shared types and codes of the dock and USB path selector.
`timescale 1ns / 1ps
`default_nettype none

package dus_pkg;

	localparam int unsigned VOLT_W  = 25;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		EV_DOCK_CHANGE  = 2'd0,
		EV_MOVE_TO_USBC = 2'd1,
		EV_RETRY_READ   = 2'd2,
		EV_USBC_CHANGED = 2'd3
	} event_kind_t;

	typedef enum logic [1:0] {
		RS_OK        = 2'd0,
		RS_NOT_READY = 2'd1,
		RS_ERROR     = 2'd2
	} read_status_t;

	typedef enum logic [1:0] {
		DLY_LOW_VOLT  = 2'd0,   // 100 ms
		DLY_NOT_READY = 2'd1,   // 500 ms
		DLY_RECHECK   = 2'd2    // 250 ms
	} delay_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATH_LOCK      = 3'd0,
		REG_USBC_HOLD      = 3'd1,
		REG_CAPABLE_THRESH = 3'd2,
		REG_RETRY_THRESH   = 3'd3,
		REG_RETRY_LIMIT    = 3'd4
	} cfg_reg_t;

	localparam logic [VOLT_W-1:0]  CAPABLE_THRESH_RST = 25'd10500000;
	localparam logic [VOLT_W-1:0]  RETRY_THRESH_RST   = 25'd7000000;
	localparam logic [COUNT_W-1:0] RETRY_LIMIT_RST    = 8'd10;

	typedef struct packed {
		logic        retry_request;
		logic [1:0]  retry_delay_code;
		logic        dock_status_update;
		logic        dock_reported;
		logic        capable_reported;
		logic        switch_to_dock;
		logic        usbc_data_off;
		logic        usbc_off_as_host;
		logic        switch_to_usbc;
		logic        dock_data_active;
		logic        change_notify;
	} result_t;

endpackage

`default_nettype wire

// File: sv/dus_if.sv
// Interfaces: event channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface dus_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic        docked;
	logic [1:0]  read_status;
	logic [24:0] voltage_uv;
	logic        usbc_data_active;
	logic        usbc_host_role;

	modport source (
		output valid, event_kind, docked, read_status, voltage_uv,
		       usbc_data_active, usbc_host_role,
		input  ready
	);
	modport sink (
		input  valid, event_kind, docked, read_status, voltage_uv,
		       usbc_data_active, usbc_host_role,
		output ready
	);
endinterface

interface dus_result_if;
	logic       valid;
	logic       ready;
	logic       retry_request;
	logic [1:0] retry_delay_code;
	logic       dock_status_update;
	logic       dock_reported;
	logic       capable_reported;
	logic       switch_to_dock;
	logic       usbc_data_off;
	logic       usbc_off_as_host;
	logic       switch_to_usbc;
	logic       dock_data_active;
	logic       change_notify;

	modport source (
		output valid, retry_request, retry_delay_code, dock_status_update,
		       dock_reported, capable_reported, switch_to_dock, usbc_data_off,
		       usbc_off_as_host, switch_to_usbc, dock_data_active, change_notify,
		input  ready
	);
	modport sink (
		input  valid, retry_request, retry_delay_code, dock_status_update,
		       dock_reported, capable_reported, switch_to_dock, usbc_data_off,
		       usbc_off_as_host, switch_to_usbc, dock_data_active, change_notify,
		output ready
	);
endinterface

`default_nettype wire

// File: sv/dock_usb_path_selector_unit.sv
// Top level: dock voltage classification and USB data path selection.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   evt    : event transactions (kind, dock pin, voltage read status and value,
//            USB-C data activity and role). One transaction may enter every cycle.
//   res    : one result transaction per event: retry request with delay code,
//            dock/capable status report, path switch pulses, notify flag.
//   cfg_*  : register write port, index selects path lock, USB-C hold,
//            capable threshold, retry threshold and retry limit. Write only
//            while no event is in flight.
// Result timing: an event's result is registered and valid in the cycle after its transaction.
// Throughput: one event per cycle if results are taken; the classification compares
//   and flag updates finish between the event handshake and the result register.
// Reset (arst_n low): flags, retry count and path state clear, registers
//   load their defaults, the result register empties.
// Stall: while a result waits, a new event is still taken if the receiver
//   takes the waiting one in the same cycle; otherwise evt.ready drops and
//   the waiting result holds unchanged.
module dock_usb_path_selector_unit
	import dus_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [VOLT_W-1:0]    cfg_wdata,
	dus_event_if.sink           evt,
	dus_result_if.source        res
);

	// Configuration registers
	logic               path_lock_q;
	logic               usbc_hold_q;
	logic [VOLT_W-1:0]  capable_thresh_q;
	logic [VOLT_W-1:0]  retry_thresh_q;
	logic [COUNT_W-1:0] retry_limit_q;

	// Selector state
	logic [COUNT_W-1:0] low_retry_count_q;
	logic               dock_capable_q;
	logic               recheck_pending_q;
	logic               dock_path_active_q;

	// Result register
	logic    res_valid_q;
	result_t res_q;

	logic               evt_accept;
	logic [COUNT_W-1:0] low_retry_count_d;
	logic               dock_capable_d;
	logic               recheck_pending_d;
	logic               dock_path_active_d;
	logic               finish;
	result_t            res_d;
	event_kind_t        kind;

	assign kind       = event_kind_t'(evt.event_kind);
	assign evt.ready  = !res_valid_q || res.ready;
	assign evt_accept = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_lock_q      <= 1'b0;
			usbc_hold_q      <= 1'b0;
			capable_thresh_q <= CAPABLE_THRESH_RST;
			retry_thresh_q   <= RETRY_THRESH_RST;
			retry_limit_q    <= RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATH_LOCK:      path_lock_q      <= cfg_wdata[0];
				REG_USBC_HOLD:      usbc_hold_q      <= cfg_wdata[0];
				REG_CAPABLE_THRESH: capable_thresh_q <= cfg_wdata;
				REG_RETRY_THRESH:   retry_thresh_q   <= cfg_wdata;
				REG_RETRY_LIMIT:    retry_limit_q    <= cfg_wdata[COUNT_W-1:0];
				default: ;  // drop writes past the register list
			endcase
		end
	end

	// Classify the voltage read, then steer the data path.
	always_comb begin
		res_d              = '0;
		finish             = 1'b1;
		low_retry_count_d  = low_retry_count_q;
		dock_capable_d     = dock_capable_q;
		recheck_pending_d  = recheck_pending_q;
		dock_path_active_d = dock_path_active_q;

		case (read_status_t'(evt.read_status))
			RS_OK: begin
				if (kind inside {EV_DOCK_CHANGE, EV_RETRY_READ}) begin
					if (evt.docked) begin
						if (evt.voltage_uv >= capable_thresh_q) begin
							dock_capable_d           = 1'b1;
							res_d.dock_status_update = 1'b1;
							res_d.dock_reported      = 1'b1;
							res_d.capable_reported   = 1'b1;
						end else if (evt.voltage_uv <= retry_thresh_q) begin
							// low band: retry until the limit, then give up silently
							if (low_retry_count_q < retry_limit_q) begin
								low_retry_count_d      = low_retry_count_q + COUNT_W'(1);
								res_d.retry_request    = 1'b1;
								res_d.retry_delay_code = DLY_LOW_VOLT;
							end
							finish = 1'b0;
						end else if (!recheck_pending_q) begin
							// middle band, first time: recheck once
							recheck_pending_d      = 1'b1;
							res_d.retry_request    = 1'b1;
							res_d.retry_delay_code = DLY_RECHECK;
							finish                 = 1'b0;
						end else begin
							dock_capable_d           = 1'b0;
							res_d.dock_status_update = 1'b1;
							res_d.dock_reported      = 1'b1;
						end
					end else begin
						// undock: clear everything
						low_retry_count_d        = '0;
						dock_capable_d           = 1'b0;
						recheck_pending_d        = 1'b0;
						res_d.dock_status_update = 1'b1;
					end
				end
			end
			RS_NOT_READY: begin
				res_d.retry_request    = 1'b1;
				res_d.retry_delay_code = DLY_NOT_READY;
				finish                 = 1'b0;
			end
			default: finish = 1'b0;
		endcase

		if (finish) begin
			if (path_lock_q) begin
				// hold the path as it is
			end else if (dock_capable_d && !dock_path_active_q) begin
				if (!(evt.usbc_data_active && usbc_hold_q)) begin
					res_d.switch_to_dock   = 1'b1;
					res_d.usbc_data_off    = evt.usbc_data_active;
					res_d.usbc_off_as_host = evt.usbc_data_active && evt.usbc_host_role;
					dock_path_active_d     = 1'b1;
				end
			end else if ((!dock_capable_d || kind == EV_MOVE_TO_USBC)
			             && dock_path_active_q) begin
				res_d.switch_to_usbc = 1'b1;
				dock_path_active_d   = 1'b0;
			end
			res_d.change_notify = 1'b1;
		end
		res_d.dock_data_active = dock_path_active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_retry_count_q  <= '0;
			dock_capable_q     <= 1'b0;
			recheck_pending_q  <= 1'b0;
			dock_path_active_q <= 1'b0;
			res_valid_q        <= 1'b0;
		end else begin
			if (evt_accept) begin
				low_retry_count_q  <= low_retry_count_d;
				dock_capable_q     <= dock_capable_d;
				recheck_pending_q  <= recheck_pending_d;
				dock_path_active_q <= dock_path_active_d;
				res_valid_q        <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload needs no reset; load only on an accepted event.
	always_ff @(posedge clk) begin
		if (evt_accept) begin
			res_q <= res_d;
		end
	end

	assign res.valid              = res_valid_q;
	assign res.retry_request      = res_q.retry_request;
	assign res.retry_delay_code   = res_q.retry_delay_code;
	assign res.dock_status_update = res_q.dock_status_update;
	assign res.dock_reported      = res_q.dock_reported;
	assign res.capable_reported   = res_q.capable_reported;
	assign res.switch_to_dock     = res_q.switch_to_dock;
	assign res.usbc_data_off      = res_q.usbc_data_off;
	assign res.usbc_off_as_host   = res_q.usbc_off_as_host;
	assign res.switch_to_usbc     = res_q.switch_to_usbc;
	assign res.dock_data_active   = res_q.dock_data_active;
	assign res.change_notify      = res_q.change_notify;

endmodule

`default_nettype wire

// File: test/dock_usb_path_selector_unit_test.sv
// Testbench: dock and USB path selector, directed table then random events checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none

module dock_usb_path_selector_unit_test;
	import dus_pkg::*;

	// Status code 3 is left unnamed by the package; the block must ignore it like an error.
	localparam logic [1:0]        RS_UNUSED    = 2'd3;
	localparam logic [VOLT_W-1:0] VOLT_MAX     = '1;
	localparam int unsigned       VOLT_TOP     = 30000000;
	localparam int unsigned       PHASE_EVENTS = 140;
	localparam int unsigned       N_RANDOM_CFG = 2;

	typedef enum int unsigned {
		PACE_STEADY,
		PACE_RANDOM,
		PACE_BURSTY
	} pace_t;

	typedef struct packed {
		event_kind_t       kind;
		logic              docked;
		logic [1:0]        status;
		logic [VOLT_W-1:0] volt;
		logic              usbc_active;
		logic              usbc_host;
	} dock_event_t;

	typedef struct packed {
		dock_event_t ev;
		logic [3:0]  reps;
		logic        typed;
		result_t     want;
	} stim_row_t;

	typedef struct packed {
		logic               path_lock;
		logic               usbc_hold;
		logic [VOLT_W-1:0]  capable_uv;
		logic [VOLT_W-1:0]  retry_uv;
		logic [COUNT_W-1:0] retry_limit;
	} selector_cfg_t;

	// Outcomes that can be read straight off the behavior, used by the typed rows.
	localparam result_t WANT_NONE      = '0;
	localparam result_t WANT_NOT_READY = '{retry_request: 1'b1,
		retry_delay_code: DLY_NOT_READY, default: '0};
	localparam result_t WANT_LOW_RETRY = '{retry_request: 1'b1,
		retry_delay_code: DLY_LOW_VOLT, default: '0};
	localparam result_t WANT_NOTIFY    = '{change_notify: 1'b1, default: '0};

	// Directed table, walked once after reset under the default register values.
	// Rows that are not typed are checked against the predictor.
	localparam int N_ROWS = 17;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		// read not ready: retry request with the long delay, nothing else
		'{'{EV_DOCK_CHANGE, 1'b1, RS_NOT_READY, 25'd0, 1'b0, 1'b0}, 4'd1, 1'b1, WANT_NOT_READY},
		// read error and the unused status do nothing at all
		'{'{EV_DOCK_CHANGE, 1'b1, RS_ERROR, 25'd12000000, 1'b1, 1'b1}, 4'd1, 1'b1, WANT_NONE},
		'{'{EV_RETRY_READ, 1'b1, RS_UNUSED, VOLT_MAX, 1'b1, 1'b1}, 4'd1, 1'b1, WANT_NONE},
		// USB-C change with nothing capable: notify only
		'{'{EV_USBC_CHANGED, 1'b1, RS_OK, 25'd0, 1'b0, 1'b0}, 4'd1, 1'b1, WANT_NOTIFY},
		// zero volts: first low-voltage retry
		'{'{EV_DOCK_CHANGE, 1'b1, RS_OK, 25'd0, 1'b0, 1'b0}, 4'd1, 1'b1, WANT_LOW_RETRY},
		// exactly at the retry threshold, then one above it (recheck)
		'{'{EV_RETRY_READ, 1'b1, RS_OK, 25'd7000000, 1'b0, 1'b0}, 4'd1, 1'b0, WANT_NONE},
		'{'{EV_DOCK_CHANGE, 1'b1, RS_OK, 25'd7000001, 1'b1, 1'b0}, 4'd1, 1'b0, WANT_NONE},
		// middle band again with recheck pending: not capable
		'{'{EV_RETRY_READ, 1'b1, RS_OK, 25'd10499999, 1'b0, 1'b0}, 4'd1, 1'b0, WANT_NONE},
		// exactly at the capable threshold with USB-C host active: take the path
		'{'{EV_DOCK_CHANGE, 1'b1, RS_OK, 25'd10500000, 1'b1, 1'b1}, 4'd1, 1'b0, WANT_NONE},
		// move data to USB-C, then USB-C change brings it back to the dock
		'{'{EV_MOVE_TO_USBC, 1'b1, RS_OK, 25'd0, 1'b0, 1'b0}, 4'd1, 1'b0, WANT_NONE},
		'{'{EV_USBC_CHANGED, 1'b1, RS_OK, 25'd0, 1'b1, 1'b0}, 4'd1, 1'b0, WANT_NONE},
		// full-scale voltage while already on the dock
		'{'{EV_DOCK_CHANGE, 1'b1, RS_OK, VOLT_MAX, 1'b0, 1'b0}, 4'd1, 1'b0, WANT_NONE},
		// undock clears every flag and hands the path back
		'{'{EV_DOCK_CHANGE, 1'b0, RS_OK, 25'd0, 1'b1, 1'b1}, 4'd1, 1'b0, WANT_NONE},
		// recheck is armed again after undocking
		'{'{EV_DOCK_CHANGE, 1'b1, RS_OK, 25'd8000000, 1'b0, 1'b0}, 4'd1, 1'b0, WANT_NONE},
		// run the low-voltage retries up to the limit, then one past it
		'{'{EV_RETRY_READ, 1'b1, RS_OK, 25'd6999999, 1'b1, 1'b1}, 4'd10, 1'b0, WANT_NONE},
		'{'{EV_RETRY_READ, 1'b1, RS_OK, 25'd3000000, 1'b0, 1'b0}, 4'd1, 1'b0, WANT_NONE},
		// capable with USB-C idle: switch without turning USB-C off
		'{'{EV_DOCK_CHANGE, 1'b1, RS_OK, 25'd20000000, 1'b0, 1'b1}, 4'd1, 1'b0, WANT_NONE}
	};

	// Register corners: defaults, path lock and USB-C hold, zero and 30000000 uV thresholds,
	// overlapping thresholds, no middle band, retry limit 0 and 255.
	localparam int N_CORNERS = 7;
	localparam selector_cfg_t CFG_CORNERS [N_CORNERS] = '{
		'{1'b0, 1'b0, 25'd10500000, 25'd7000000, 8'd10},
		'{1'b0, 1'b1, 25'd10500000, 25'd7000000, 8'd3},
		'{1'b1, 1'b0, 25'd12000000, 25'd5000000, 8'd0},
		'{1'b0, 1'b0, 25'd0, 25'd0, 8'd255},
		'{1'b0, 1'b1, 25'd30000000, 25'd30000000, 8'd255},
		'{1'b1, 1'b1, 25'd5000000, 25'd9000000, 8'd1},
		'{1'b0, 1'b0, 25'd9000000, 25'd8999999, 8'd2}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VOLT_W-1:0]    cfg_wdata;

	dus_event_if  evt_if ();
	dus_result_if res_if ();

	dock_usb_path_selector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_if),
		.res       (res_if)
	);

	always #5 clk = ~clk;

	// Predictor state: the selector's flags and its register copy.
	selector_cfg_t      model_cfg = '{1'b0, 1'b0, CAPABLE_THRESH_RST, RETRY_THRESH_RST,
		RETRY_LIMIT_RST};
	logic [COUNT_W-1:0] retries_used  = '0;
	logic               capable_flag  = 1'b0;
	logic               recheck_armed = 1'b0;
	logic               dock_path_on  = 1'b0;

	result_t     pending_outcomes [$];
	int unsigned events_sent      = 0;
	int unsigned outcomes_checked = 0;
	int unsigned settings_applied = 0;
	int unsigned failures         = 0;
	pace_t       send_pace        = PACE_STEADY;

	// Classify the voltage, update the flags, then steer the data path.
	function automatic result_t selector_step(dock_event_t e);
		result_t r;
		logic    settle;
		r = '0;
		settle = 1'b1;
		if (e.status != RS_OK) begin
			if (e.status == RS_NOT_READY) begin
				r.retry_request    = 1'b1;
				r.retry_delay_code = DLY_NOT_READY;
			end
			settle = 1'b0;
		end else if (e.kind == EV_DOCK_CHANGE || e.kind == EV_RETRY_READ) begin
			if (!e.docked) begin
				retries_used         = '0;
				capable_flag         = 1'b0;
				recheck_armed        = 1'b0;
				r.dock_status_update = 1'b1;
			end else if (e.volt >= model_cfg.capable_uv) begin
				// capable test comes first, so overlapping thresholds favor it
				capable_flag         = 1'b1;
				r.dock_status_update = 1'b1;
				r.dock_reported      = 1'b1;
				r.capable_reported   = 1'b1;
			end else if (e.volt <= model_cfg.retry_uv) begin
				if (retries_used < model_cfg.retry_limit) begin
					retries_used       = retries_used + COUNT_W'(1);
					r.retry_request    = 1'b1;
					r.retry_delay_code = DLY_LOW_VOLT;
				end
				settle = 1'b0;
			end else if (!recheck_armed) begin
				recheck_armed      = 1'b1;
				r.retry_request    = 1'b1;
				r.retry_delay_code = DLY_RECHECK;
				settle             = 1'b0;
			end else begin
				capable_flag         = 1'b0;
				r.dock_status_update = 1'b1;
				r.dock_reported      = 1'b1;
			end
		end
		if (settle) begin
			if (!model_cfg.path_lock) begin
				if (capable_flag && !dock_path_on) begin
					if (!(e.usbc_active && model_cfg.usbc_hold)) begin
						r.switch_to_dock   = 1'b1;
						r.usbc_data_off    = e.usbc_active;
						r.usbc_off_as_host = e.usbc_active & e.usbc_host;
						dock_path_on       = 1'b1;
					end
				end else if ((!capable_flag || e.kind == EV_MOVE_TO_USBC) && dock_path_on) begin
					r.switch_to_usbc = 1'b1;
					dock_path_on     = 1'b0;
				end
			end
			r.change_notify = 1'b1;
		end
		r.dock_data_active = dock_path_on;
		return r;
	endfunction

	function automatic int unsigned draw_wait(pace_t pace);
		case (pace)
			PACE_STEADY: begin
				return 0;
			end
			PACE_RANDOM: begin
				return $urandom_range(0, 18);
			end
			default: begin
				return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
			end
		endcase
	endfunction

	// Aim most voltages at the band edges and inside the bands of the current settings.
	function automatic logic [VOLT_W-1:0] pick_voltage();
		int unsigned cap, rty, hi;
		cap = model_cfg.capable_uv;
		rty = model_cfg.retry_uv;
		hi  = (cap + 3000000 > VOLT_MAX) ? VOLT_MAX : cap + 3000000;
		case ($urandom_range(0, 9))
			0: begin
				return VOLT_W'(cap);
			end
			1: begin
				return VOLT_W'(rty);
			end
			2: begin
				return VOLT_W'(rty + 1);
			end
			3: begin
				return (cap == 0) ? '0 : VOLT_W'(cap - 1);
			end
			4, 5: begin
				return VOLT_W'($urandom_range(cap, hi));
			end
			6: begin
				return VOLT_W'($urandom_range(0, rty));
			end
			8: begin
				return VOLT_W'($urandom_range(0, VOLT_MAX));
			end
			default: begin
				if (cap > rty + 1)
					return VOLT_W'($urandom_range(rty + 1, cap - 1));
				return VOLT_W'($urandom_range(0, VOLT_TOP));
			end
		endcase
	endfunction

	// Mostly docked, well-read classification events; the rest is noise.
	function automatic dock_event_t random_event();
		dock_event_t e;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		e.kind = (pick < 35) ? EV_DOCK_CHANGE :
			(pick < 70) ? EV_RETRY_READ :
			(pick < 85) ? EV_MOVE_TO_USBC : EV_USBC_CHANGED;
		e.docked = ($urandom_range(0, 6) != 0);
		pick = $urandom_range(0, 19);
		e.status = (pick < 16) ? RS_OK :
			(pick < 18) ? RS_NOT_READY :
			(pick == 18) ? RS_ERROR : RS_UNUSED;
		e.volt        = pick_voltage();
		e.usbc_active = 1'($urandom_range(0, 1));
		e.usbc_host   = 1'($urandom_range(0, 1));
		return e;
	endfunction

	function automatic selector_cfg_t random_settings();
		selector_cfg_t s;
		s.path_lock   = ($urandom_range(0, 3) == 0);
		s.usbc_hold   = 1'($urandom_range(0, 1));
		s.capable_uv  = VOLT_W'($urandom_range(0, VOLT_TOP));
		s.retry_uv    = ($urandom_range(0, 3) == 0) ? VOLT_W'($urandom_range(0, VOLT_TOP)) :
			VOLT_W'($urandom_range(0, s.capable_uv));
		s.retry_limit = ($urandom_range(0, 1) == 0) ? COUNT_W'($urandom_range(0, 12)) :
			COUNT_W'($urandom_range(0, 255));
		return s;
	endfunction

	// Present one event after a random gap, hold it until taken, then predict its outcome.
	// Valid stays high for back-to-back events so it is never dropped and raised in one step.
	task automatic send_event(dock_event_t e, logic typed, result_t want);
		int unsigned gap;
		result_t     outcome;
		if (events_sent % 50 == 0)
			send_pace = pace_t'($urandom_range(0, 2));
		gap = draw_wait(send_pace);
		if (gap != 0) begin
			evt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_if.valid            <= 1'b1;
		evt_if.event_kind       <= e.kind;
		evt_if.docked           <= e.docked;
		evt_if.read_status      <= e.status;
		evt_if.voltage_uv       <= e.volt;
		evt_if.usbc_data_active <= e.usbc_active;
		evt_if.usbc_host_role   <= e.usbc_host;
		do @(posedge clk); while (!evt_if.ready);
		outcome = selector_step(e);
		pending_outcomes.push_back(typed ? want : outcome);
		events_sent++;
	endtask

	// Hold off new events until every predicted outcome has come back.
	task automatic drain();
		if (evt_if.valid)
			evt_if.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Write enable stays high across back-to-back writes; the caller drops it.
	task automatic write_reg(cfg_reg_t idx, logic [VOLT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic apply_settings(selector_cfg_t s);
		write_reg(REG_PATH_LOCK, VOLT_W'(s.path_lock));
		write_reg(REG_USBC_HOLD, VOLT_W'(s.usbc_hold));
		write_reg(REG_CAPABLE_THRESH, s.capable_uv);
		write_reg(REG_RETRY_THRESH, s.retry_uv);
		write_reg(REG_RETRY_LIMIT, VOLT_W'(s.retry_limit));
		cfg_we <= 1'b0;
		model_cfg = s;
		settings_applied++;
	endtask

	task automatic compare_field(string name, logic [1:0] want, logic [1:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			failures++;
		end
	endtask

	// Result receiver: stall at random before each transaction.
	initial begin
		int unsigned stall;
		int unsigned taken;
		pace_t       take_pace;
		res_if.ready = 1'b0;
		taken        = 0;
		take_pace    = PACE_STEADY;
		forever begin
			if (taken % 50 == 0)
				take_pace = pace_t'($urandom_range(0, 2));
			stall = draw_wait(take_pace);
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!(arst_n && res_if.valid));
			taken++;
		end
	end

	// Compare every accepted result with the oldest predicted outcome.
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			seen = {res_if.retry_request, res_if.retry_delay_code, res_if.dock_status_update,
				res_if.dock_reported, res_if.capable_reported, res_if.switch_to_dock,
				res_if.usbc_data_off, res_if.usbc_off_as_host, res_if.switch_to_usbc,
				res_if.dock_data_active, res_if.change_notify};
			if (pending_outcomes.size() == 0) begin
				$error("result transaction with no event outstanding");
				failures++;
			end else begin
				want = pending_outcomes.pop_front();
				compare_field("retry_request", want.retry_request, seen.retry_request);
				compare_field("retry_delay_code", want.retry_delay_code,
					seen.retry_delay_code);
				compare_field("dock_status_update", want.dock_status_update,
					seen.dock_status_update);
				compare_field("dock_reported", want.dock_reported, seen.dock_reported);
				compare_field("capable_reported", want.capable_reported,
					seen.capable_reported);
				compare_field("switch_to_dock", want.switch_to_dock, seen.switch_to_dock);
				compare_field("usbc_data_off", want.usbc_data_off, seen.usbc_data_off);
				compare_field("usbc_off_as_host", want.usbc_off_as_host,
					seen.usbc_off_as_host);
				compare_field("switch_to_usbc", want.switch_to_usbc, seen.switch_to_usbc);
				compare_field("dock_data_active", want.dock_data_active,
					seen.dock_data_active);
				compare_field("change_notify", want.change_notify, seen.change_notify);
				outcomes_checked++;
			end
		end
	end

	// Stimulus: reset, directed table, then random phases under changing register settings.
	initial begin
		int unsigned row, rep, phase, k;
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = REG_PATH_LOCK;
		cfg_wdata               = '0;
		evt_if.valid            = 1'b0;
		evt_if.event_kind       = EV_DOCK_CHANGE;
		evt_if.docked           = 1'b0;
		evt_if.read_status      = RS_OK;
		evt_if.voltage_uv       = '0;
		evt_if.usbc_data_active = 1'b0;
		evt_if.usbc_host_role   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < N_ROWS; row++)
			for (rep = 0; rep < DIRECTED[row].reps; rep++)
				send_event(DIRECTED[row].ev, DIRECTED[row].typed, DIRECTED[row].want);

		for (phase = 0; phase < N_CORNERS + N_RANDOM_CFG; phase++) begin
			// registers change only with nothing in flight
			drain();
			apply_settings((phase < N_CORNERS) ? CFG_CORNERS[phase] : random_settings());
			for (k = 0; k < PHASE_EVENTS; k++) begin
				if ($urandom_range(0, 199) == 0)
					drain();
				send_event(random_event(), 1'b0, WANT_NONE);
			end
		end

		// Wait out the last results, then wait on so that a stray transaction would show.
		drain();
		repeat (4) @(posedge clk);
		$display("Sent %0d dock and USB-C events under %0d register settings;",
			events_sent, settings_applied);
		$display("checked %0d selector results, %0d field mismatches.",
			outcomes_checked, failures);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Time limit: well beyond the slowest correct run.
	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
